FILE: sv/bmadd_pkg.sv
// Shared widths, register indexes and types for the Barrett multiply-add block.
`default_nettype none

package bmadd_pkg;

   // Datapath widths.
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned QMOD_W    = 61;
   localparam int unsigned HALF_W    = 32;
   localparam int unsigned SHIFT_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;

   // Number of register stages between the request and the response side.
   localparam int unsigned NSTAGE = 14;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BARRETT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MULTIPLIER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ADD_EN     = 3'd4;

   // Input range factor codes.
   localparam logic [1:0] RANGE_X1 = 2'd0;
   localparam logic [1:0] RANGE_X2 = 2'd1;
   localparam logic [1:0] RANGE_X4 = 2'd2;
   localparam logic [1:0] RANGE_X8 = 2'd3;

   // Reset values and limits of the configuration.
   localparam logic [QMOD_W-1:0]  MODULUS_RST = 61'd4;
   localparam logic [QMOD_W-1:0]  MODULUS_MIN = 61'd4;
   localparam logic [DATA_W-1:0]  BARRETT_RST = 64'h8000_0000_0000_0000;
   localparam logic [SHIFT_W-1:0] SHIFT_RST   = 6'd1;

   // Per-item side information that travels with the datapath.
   typedef struct packed {
      logic              err;
      logic              last;
      logic [DATA_W-1:0] addend;
   } side_type;

endpackage

`default_nettype wire

FILE: sv/bmadd_req_if.sv
// Request channel interface: multiplicand, addend and end-of-vector mark.
`default_nettype none

interface bmadd_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmadd_pkg::DATA_W-1:0]     multiplicand;
   logic [bmadd_pkg::DATA_W-1:0]     addend;
   logic                             last_in;

   modport source (output valid, output multiplicand, output addend, output last_in,
                   input ready);
   modport sink   (input valid, input multiplicand, input addend, input last_in,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/bmadd_rsp_if.sv
// Response channel interface: residue, range error flag and end-of-vector mark.
`default_nettype none

interface bmadd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bmadd_pkg::QMOD_W-1:0]     residue;
   logic                             range_error;
   logic                             last_out;

   modport source (output valid, output residue, output range_error, output last_out,
                   input ready);
   modport sink   (input valid, input residue, input range_error, input last_out,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/modular_multiply_add_barrett_core.sv
// Top level: pipelined Barrett modular multiply-add, (x*y + a) mod q.
//
//   Channel  Direction  Handshake         Contents
//   req      in         valid / ready     multiplicand, addend, last_in
//   rsp      out        valid / ready     residue, range_error, last_out
//   csr      in         csr_we            csr_index, csr_wdata (write only)
//
// One item enters per cycle unless every stage is full and the response side stalls;
// each result passes the fourteen register stages of cut, multiply and Barrett reduction.
// Every multiply is split into 32x32 partial products with a register behind it.
// Each stage holds its item only while the stage after it is full and stalled, so
// bubbles close up and the request side keeps taking items while a result waits, until every stage is full.
// Reset (synchronous) clears the stage valid bits and loads the register defaults.
`default_nettype none

module modular_multiply_add_barrett_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bmadd_req_if.sink                                req,
   bmadd_rsp_if.source                              rsp,
   input  wire logic                                csr_we,
   input  wire logic [bmadd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bmadd_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int unsigned DW = bmadd_pkg::DATA_W;
   localparam int unsigned QW = bmadd_pkg::QMOD_W;
   localparam int unsigned HW = bmadd_pkg::HALF_W;
   localparam int unsigned NS = bmadd_pkg::NSTAGE;

   // Conditional subtraction used by the input cut and the final correction.
   function automatic logic [DW-1:0] cut_step(input logic [DW-1:0] v,
                                              input logic [DW-1:0] m,
                                              input logic          en);
      return (en && (v >= m)) ? (v - m) : v;
   endfunction

   // Unsigned 32x32 partial product.
   function automatic logic [2*HW-1:0] mul_half(input logic [HW-1:0] a,
                                                input logic [HW-1:0] b);
      return a * b;
   endfunction

   // Position of the leading one of the modulus, plus one.
   function automatic logic [bmadd_pkg::SHIFT_W-1:0] bit_width(input logic [QW-1:0] v);
      logic [bmadd_pkg::SHIFT_W-1:0] n;
      n = '0;
      for (int i = 0; i < QW; i++) begin
         if (v[i]) n = bmadd_pkg::SHIFT_W'(i + 1);
      end
      return n;
   endfunction

   // Configuration registers.
   logic [QW-1:0]                      modulus_ff;
   logic [DW-1:0]                      barrett_ff;
   logic [DW-1:0]                      multiplier_ff;
   logic [1:0]                         range_ff;
   logic                               add_en_ff;
   logic [bmadd_pkg::SHIFT_W-1:0]      shift_ff;
   logic [bmadd_pkg::SHIFT_W-1:0]      shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= bmadd_pkg::MODULUS_RST;
         barrett_ff    <= bmadd_pkg::BARRETT_RST;
         multiplier_ff <= '0;
         range_ff      <= bmadd_pkg::RANGE_X1;
         add_en_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            bmadd_pkg::REG_MODULUS:    modulus_ff    <= csr_wdata[QW-1:0];
            bmadd_pkg::REG_BARRETT:    barrett_ff    <= csr_wdata;
            bmadd_pkg::REG_MULTIPLIER: multiplier_ff <= csr_wdata;
            bmadd_pkg::REG_RANGE:      range_ff      <= csr_wdata[1:0];
            bmadd_pkg::REG_ADD_EN:     add_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Product shift is bitwidth(q) - 2; it is first used six stages in.
   assign shift_in = bit_width(modulus_ff) - bmadd_pkg::SHIFT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= bmadd_pkg::SHIFT_RST;
      end else begin
         shift_ff <= shift_in;
      end
   end

   // Multiples of the modulus and the input limit.
   logic [DW-1:0] q1;
   logic [DW-1:0] q2;
   logic [DW-1:0] q4;
   logic [DW-1:0] limit;
   logic          en_cut4;
   logic          en_cut2;
   logic          en_cut1;

   assign q1      = {3'b000, modulus_ff};
   assign q2      = {2'b00, modulus_ff, 1'b0};
   assign q4      = {1'b0, modulus_ff, 2'b00};
   assign limit   = q1 << range_ff;
   assign en_cut4 = (range_ff == bmadd_pkg::RANGE_X8);
   assign en_cut2 = (range_ff == bmadd_pkg::RANGE_X8) || (range_ff == bmadd_pkg::RANGE_X4);
   assign en_cut1 = (range_ff != bmadd_pkg::RANGE_X1);

   // Stage valid bits and the per-stage advance chain.
   logic [NS:1]   valid_ff;
   logic [NS+1:1] adv;

   always_comb begin
      adv[NS+1] = rsp.ready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) valid_ff[1] <= req.valid;
         for (int k = 2; k <= NS; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Side information moves with each item.
   bmadd_pkg::side_type side_ff [1:NS];
   bmadd_pkg::side_type s1_side_in;
   bmadd_pkg::side_type s2_side_in;
   bmadd_pkg::side_type s3_side_in;

   // Stage 1: range check and the 4q cut.
   logic [DW-1:0] s1_x_in, s1_y_in, s1_x_ff, s1_y_ff;
   logic          s1_err_in;

   assign s1_err_in = (modulus_ff < bmadd_pkg::MODULUS_MIN) || (req.multiplicand >= limit) ||
                      (multiplier_ff >= limit) || (add_en_ff && (req.addend >= limit));
   assign s1_x_in   = cut_step(req.multiplicand, q4, en_cut4);
   assign s1_y_in   = cut_step(multiplier_ff, q4, en_cut4);

   always_comb begin
      s1_side_in.err    = s1_err_in;
      s1_side_in.last   = req.last_in;
      s1_side_in.addend = cut_step(req.addend, q4, en_cut4);
   end

   // Stages 2 and 3: the 2q and q cuts.
   logic [DW-1:0] s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff;

   always_comb begin
      s2_side_in        = side_ff[1];
      s2_side_in.addend = cut_step(side_ff[1].addend, q2, en_cut2);
      s3_side_in        = side_ff[2];
      s3_side_in.addend = cut_step(side_ff[2].addend, q1, en_cut1);
   end

   // Stage 4: partial products of x*y.
   logic [2*HW-1:0] s4_p00_ff, s4_p01_ff, s4_p10_ff, s4_p11_ff;

   // Stage 5: full 128-bit product.
   logic [2*DW-1:0] s5_prod_in, s5_prod_ff;

   assign s5_prod_in = {s4_p11_ff, s4_p00_ff} + ((2*DW)'(s4_p01_ff) << HW) +
                       ((2*DW)'(s4_p10_ff) << HW);

   // Stage 6: shifted product c and the low word of the product.
   logic [DW-1:0] s6_c_in, s6_c_ff;
   logic [DW-1:0] s6_lo_ff, s7_lo_ff, s8_lo_ff, s9_lo_ff;

   assign s6_c_in = DW'(s5_prod_ff >> shift_ff);

   // Stage 7: partial products of c*mu.
   logic [2*HW-1:0] s7_m00_ff, s7_m01_ff, s7_m10_ff, s7_m11_ff;

   // Stage 8: quotient estimate, the high word of c*mu.
   logic [2*DW-1:0] s8_full;
   logic [DW-1:0]   s8_qhat_ff;

   assign s8_full = {s7_m11_ff, s7_m00_ff} + ((2*DW)'(s7_m01_ff) << HW) +
                    ((2*DW)'(s7_m10_ff) << HW);

   // Stage 9: partial products of the low word of qhat*q.
   logic [2*HW-1:0] s9_n00_ff;
   logic [HW-1:0]   s9_n01_ff, s9_n10_ff;
   logic [2*HW-1:0] s9_n01_in, s9_n10_in;

   assign s9_n01_in = mul_half(s8_qhat_ff[HW-1:0], {3'b000, modulus_ff[QW-1:HW]});
   assign s9_n10_in = mul_half(s8_qhat_ff[DW-1:HW], modulus_ff[HW-1:0]);

   // Stage 10: remainder estimate in [0,4q) for a correct mu.
   logic [HW-1:0] s10_mid;
   logic [DW-1:0] s10_z_in, s10_z_ff;

   assign s10_mid  = s9_n01_ff + s9_n10_ff;
   assign s10_z_in = s9_lo_ff - s9_n00_ff - {s10_mid, {HW{1'b0}}};

   // Stages 11 to 14: correction, optional addend and final reduction.
   logic [DW-1:0] s11_z_ff, s12_z_ff, s13_z_in, s13_z_ff, s14_sum;
   logic [QW-1:0] s14_res_in, s14_res_ff;

   assign s13_z_in   = add_en_ff ? (s12_z_ff + side_ff[12].addend) : s12_z_ff;
   assign s14_sum    = cut_step(s13_z_ff, q1, add_en_ff);
   assign s14_res_in = side_ff[13].err ? '0 : s14_sum[QW-1:0];

   // Datapath registers, each loaded when its stage advances.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         side_ff[1] <= s1_side_in;
      end
      if (adv[2]) begin
         s2_x_ff    <= cut_step(s1_x_ff, q2, en_cut2);
         s2_y_ff    <= cut_step(s1_y_ff, q2, en_cut2);
         side_ff[2] <= s2_side_in;
      end
      if (adv[3]) begin
         s3_x_ff    <= cut_step(s2_x_ff, q1, en_cut1);
         s3_y_ff    <= cut_step(s2_y_ff, q1, en_cut1);
         side_ff[3] <= s3_side_in;
      end
      for (int k = 4; k <= NS; k++) begin
         if (adv[k]) side_ff[k] <= side_ff[k-1];
      end
      if (adv[4]) begin
         s4_p00_ff <= mul_half(s3_x_ff[HW-1:0], s3_y_ff[HW-1:0]);
         s4_p01_ff <= mul_half(s3_x_ff[HW-1:0], s3_y_ff[DW-1:HW]);
         s4_p10_ff <= mul_half(s3_x_ff[DW-1:HW], s3_y_ff[HW-1:0]);
         s4_p11_ff <= mul_half(s3_x_ff[DW-1:HW], s3_y_ff[DW-1:HW]);
      end
      if (adv[5]) s5_prod_ff <= s5_prod_in;
      if (adv[6]) begin
         s6_c_ff  <= s6_c_in;
         s6_lo_ff <= s5_prod_ff[DW-1:0];
      end
      if (adv[7]) begin
         s7_m00_ff <= mul_half(s6_c_ff[HW-1:0], barrett_ff[HW-1:0]);
         s7_m01_ff <= mul_half(s6_c_ff[HW-1:0], barrett_ff[DW-1:HW]);
         s7_m10_ff <= mul_half(s6_c_ff[DW-1:HW], barrett_ff[HW-1:0]);
         s7_m11_ff <= mul_half(s6_c_ff[DW-1:HW], barrett_ff[DW-1:HW]);
         s7_lo_ff  <= s6_lo_ff;
      end
      if (adv[8]) begin
         s8_qhat_ff <= s8_full[2*DW-1:DW];
         s8_lo_ff   <= s7_lo_ff;
      end
      if (adv[9]) begin
         s9_n00_ff <= mul_half(s8_qhat_ff[HW-1:0], modulus_ff[HW-1:0]);
         s9_n01_ff <= s9_n01_in[HW-1:0];
         s9_n10_ff <= s9_n10_in[HW-1:0];
         s9_lo_ff  <= s8_lo_ff;
      end
      if (adv[10]) s10_z_ff   <= s10_z_in;
      if (adv[11]) s11_z_ff   <= cut_step(s10_z_ff, q2, 1'b1);
      if (adv[12]) s12_z_ff   <= cut_step(s11_z_ff, q1, 1'b1);
      if (adv[13]) s13_z_ff   <= s13_z_in;
      if (adv[14]) s14_res_ff <= s14_res_in;
   end

   // Response side is the last stage.
   assign rsp.valid       = valid_ff[NS];
   assign rsp.residue     = s14_res_ff;
   assign rsp.range_error = side_ff[NS].err;
   assign rsp.last_out    = side_ff[NS].last;

   // An out-of-range item always leaves with a zero residue.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.range_error) |-> (rsp.residue == '0))
      else $error("range error result with nonzero residue");

   // The request side only stalls when every stage holds an item.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (&valid_ff))
      else $error("request stalled while a stage is empty");

   // A transfer on the request side always lands in the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_ff[1])
      else $error("accepted item did not enter the first stage");

endmodule

`default_nettype wire

FILE: tb/sv/modular_multiply_add_barrett_core_checker.sv
// Checker that predicts every Barrett multiply-add result and compares it with the block's output.
`default_nettype none

module modular_multiply_add_barrett_core_checker
   import bmadd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   bmadd_req_if                      req_mon,
   bmadd_rsp_if                      rsp_mon,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   output int unsigned               fail_count,
   output int unsigned               pending_count
);

   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [QMOD_W-1:0] residue;
      logic              range_error;
      logic              last_out;
   } residue_item_t;

   // Shadow copy of the configuration registers.
   logic [QMOD_W-1:0] cfg_modulus;
   logic [DATA_W-1:0] cfg_barrett;
   logic [DATA_W-1:0] cfg_multiplier;
   logic [1:0]        cfg_range;
   logic              cfg_add;

   residue_item_t     residue_queue[$];
   int unsigned       report_count;

   // Conditional subtraction of 4q, 2q and q as far as the range factor calls for.
   function automatic logic [DATA_W-1:0] cut_to_modulus(input logic [DATA_W-1:0] v,
                                                        input logic [DATA_W-1:0] q);
      if (cfg_range == RANGE_X8 && v >= 4 * q) v = v - 4 * q;
      if (cfg_range >= RANGE_X4 && v >= 2 * q) v = v - 2 * q;
      if (cfg_range >= RANGE_X2 && v >= q) v = v - q;
      return v;
   endfunction

   // Full Barrett datapath for one element under the current configuration.
   function automatic residue_item_t predict_residue(input logic [DATA_W-1:0] x,
                                                     input logic [DATA_W-1:0] a,
                                                     input logic              last);
      residue_item_t     r;
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] xc;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] qhat;
      logic [DATA_W-1:0] z;
      logic [127:0]      prod;
      logic [127:0]      est;
      int unsigned       shift;
      q   = {3'b000, cfg_modulus};
      lim = q << cfg_range;
      r.last_out    = last;
      r.residue     = '0;
      r.range_error = (q < 4) || (x >= lim) || (cfg_multiplier >= lim) ||
                      (cfg_add && a >= lim);
      if (!r.range_error) begin
         shift = $clog2(q + 1) - 2;
         y     = cut_to_modulus(cfg_multiplier, q);
         xc    = cut_to_modulus(x, q);
         prod  = {64'd0, xc} * {64'd0, y};
         est   = prod >> shift;
         c     = est[63:0];
         est   = {64'd0, c} * {64'd0, cfg_barrett};
         qhat  = est[127:64];
         z     = prod[63:0] - qhat * q;
         if (z >= 2 * q) z = z - 2 * q;
         if (z >= q) z = z - q;
         if (cfg_add) begin
            z = z + cut_to_modulus(a, q);
            if (z >= q) z = z - q;
         end
         r.residue = z[QMOD_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      residue_item_t got;
      residue_item_t want;
      if (reset) begin
         cfg_modulus    = MODULUS_RST;
         cfg_barrett    = BARRETT_RST;
         cfg_multiplier = '0;
         cfg_range      = RANGE_X1;
         cfg_add        = 1'b0;
         residue_queue.delete();
         fail_count     = 0;
         report_count   = 0;
      end else begin
         // A result transfer is checked against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.residue     = rsp_mon.residue;
            got.range_error = rsp_mon.range_error;
            got.last_out    = rsp_mon.last_out;
            if (residue_queue.size() == 0) begin
               fail_count = fail_count + 1;
               if (report_count < MAX_REPORTS) begin
                  report_count = report_count + 1;
                  $display("residue check: result with nothing pending, residue %0d flag %0b",
                           got.residue, got.range_error);
               end
            end else begin
               want = residue_queue.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  if (report_count < MAX_REPORTS) begin
                     report_count = report_count + 1;
                     $display("residue check: residue exp %0d got %0d, flag exp %0b got %0b, %s",
                              want.residue, got.residue, want.range_error, got.range_error,
                              $sformatf("last exp %0b got %0b", want.last_out, got.last_out));
                  end
               end
            end
         end

         // Each request transfer adds one prediction.
         if (req_mon.valid && req_mon.ready) begin
            residue_queue.push_back(predict_residue(req_mon.multiplicand, req_mon.addend,
                                                    req_mon.last_in));
         end

         // Track register writes so later predictions see the new settings.
         if (csr_we) begin
            case (csr_index)
               REG_MODULUS:    cfg_modulus    = csr_wdata[QMOD_W-1:0];
               REG_BARRETT:    cfg_barrett    = csr_wdata;
               REG_MULTIPLIER: cfg_multiplier = csr_wdata;
               REG_RANGE:      cfg_range      = csr_wdata[1:0];
               REG_ADD_EN:     cfg_add        = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending_count = residue_queue.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/modular_multiply_add_barrett_core_tb.sv
// Testbench top: stimulus, flow control and verdict for the Barrett multiply-add core.
`default_nettype none

module modular_multiply_add_barrett_core_tb;
   import bmadd_pkg::*;

   localparam int unsigned          HOLD_CYCLES  = 200;
   localparam int unsigned          PHASE_COUNT  = 16;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED   = 3'd7;
   localparam logic [DATA_W-1:0]    ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0]    MODULUS_MAX  = 64'h1FFF_FFFF_FFFF_FFFF;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;
   int unsigned          fail_count;
   int unsigned          pending_count;

   // Flow control knobs: the sender's idle share, the receiver's stall share and the hold-off request.
   int unsigned          send_idle_pct;
   int unsigned          stall_pct;
   bit                   hold_req;

   // Settings as the block sees them, used to aim the operands.
   logic [DATA_W-1:0]    cur_q;
   logic [DATA_W-1:0]    cur_lim;
   logic [1:0]           cur_code;

   bmadd_req_if req_ch ();
   bmadd_rsp_if rsp_ch ();

   modular_multiply_add_barrett_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   modular_multiply_add_barrett_core_checker residue_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #4_000_000;
      $display("[modular_multiply_add_barrett_core] ERROR");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off when the sender asks for one.
   initial begin
      int unsigned k;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
      end
   end

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Correct Barrett factor, floor(2^(bitwidth(q)+62) / q).
   function automatic logic [DATA_W-1:0] barrett_for(input logic [DATA_W-1:0] q);
      logic [127:0] num;
      num = 128'd1 << ($clog2(q + 1) + 62);
      num = num / {64'd0, q};
      return num[63:0];
   endfunction

   // Operand mostly in range, with boundaries and some out-of-range values.
   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] v;
      int unsigned       sel;
      int unsigned       k;
      sel = $urandom_range(99);
      if (sel < 65) begin
         v = rand64() % cur_lim;
      end else if (sel < 73) begin
         v = cur_lim - 1 - 64'($urandom_range(3));
      end else if (sel < 78) begin
         v = 64'($urandom_range(3));
      end else if (sel < 86) begin
         k = $urandom_range(1 << cur_code, 1);
         v = 64'(k) * cur_q - 64'($urandom_range(1, 0));
      end else if (sel < 93) begin
         v = cur_lim + 64'($urandom_range(3));
      end else begin
         v = rand64();
      end
      return v;
   endfunction

   // Stop offering items and wait until every predicted result has arrived.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes every register once the block is idle.
   task automatic apply_settings(input logic [DATA_W-1:0] q_word,
                                 input logic [DATA_W-1:0] mu,
                                 input logic [DATA_W-1:0] y,
                                 input logic [DATA_W-1:0] range_word,
                                 input logic [DATA_W-1:0] add_word,
                                 input bit                poke_unused);
      drain_pipeline();
      csr_write(REG_MODULUS, q_word);
      csr_write(REG_BARRETT, mu);
      csr_write(REG_MULTIPLIER, y);
      csr_write(REG_RANGE, range_word);
      csr_write(REG_ADD_EN, add_word);
      if (poke_unused) csr_write(REG_UNUSED, rand64());
      csr_we <= 1'b0;
      @(negedge clock);
      cur_q    = {3'b000, q_word[QMOD_W-1:0]};
      cur_code = range_word[1:0];
      cur_lim  = cur_q << cur_code;
   endtask

   // Offers one item from a falling edge and returns at the falling edge after its transfer.
   task automatic send_item(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] a,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.multiplicand <= x;
      req_ch.addend       <= a;
      req_ch.last_in      <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned       phase;
      int unsigned       i;
      int unsigned       n_items;
      int unsigned       bw;
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] mu;
      logic [DATA_W-1:0] q_word;
      logic [DATA_W-1:0] range_word;
      logic [1:0]        code;
      logic              add;
      int unsigned       y_sel;

      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.multiplicand = '0;
      req_ch.addend       = '0;
      req_ch.last_in      = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_req            = 1'b0;
      cur_q               = {3'b000, MODULUS_RST};
      cur_code            = RANGE_X1;
      cur_lim             = cur_q;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: q of four, multiplier zero, no addition.
      send_item(64'd0, ALL_ONES, 1'b0);
      send_item(64'd3, 64'd0, 1'b1);
      send_item(64'd4, 64'd0, 1'b0);

      // Largest modulus with the widest range factor and addition on.
      q = MODULUS_MAX;
      apply_settings(q, barrett_for(q), (q << RANGE_X8) - 1, {62'd0, RANGE_X8}, 64'd1, 1'b0);
      send_item(64'd0, 64'd0, 1'b0);
      send_item(cur_lim - 1, cur_lim - 1, 1'b1);
      send_item(cur_lim, 64'd0, 1'b0);
      send_item(64'd0, cur_lim, 1'b0);
      send_item(ALL_ONES, ALL_ONES, 1'b1);
      send_item(q - 1, q, 1'b0);

      // Addition off: the addend is ignored even when out of range.
      apply_settings(q, barrett_for(q), q, {62'd0, RANGE_X8}, 64'd0, 1'b0);
      send_item(64'd5, ALL_ONES, 1'b0);
      send_item(cur_lim - 1, ALL_ONES, 1'b1);
      send_item(rand64() % cur_lim, rand64(), 1'b0);

      // Modulus below four, once directly and once through the masked upper bits.
      apply_settings(64'd3, 64'd0, 64'd0, {62'd0, RANGE_X1}, 64'd0, 1'b1);
      send_item(64'd0, 64'd0, 1'b0);
      send_item(64'd1, 64'd0, 1'b1);
      apply_settings(64'hE000_0000_0000_0000, BARRETT_RST, 64'd0, {62'd0, RANGE_X1}, 64'd0,
                     1'b0);
      send_item(64'd0, 64'd0, 1'b0);

      // Smallest modulus with junk in the unused register bits.
      apply_settings(64'd4, barrett_for(64'd4), 64'd3, 64'hFFFF_FFFF_FFFF_FFFC, ALL_ONES, 1'b0);
      send_item(64'd3, 64'd3, 1'b1);
      send_item(64'd2, 64'd1, 1'b0);
      send_item(64'd4, 64'd0, 1'b0);
      send_item(64'd0, 64'd4, 1'b0);

      // A wrong Barrett factor still runs the same datapath.
      q = rand64() & MODULUS_MAX | 64'h1000_0000_0000_0000;
      apply_settings(q, rand64() >> 1, rand64() % (q << RANGE_X4), {62'd0, RANGE_X4}, 64'd1,
                     1'b0);
      for (i = 0; i < 3; i++) send_item(pick_operand(), pick_operand(), i[0]);

      // Random phases, each under its own settings and flow-control mode.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase

         case (phase % 5)
            0: begin q = MODULUS_MAX; code = RANGE_X8; end
            1: begin q = 64'd4 + 64'($urandom_range(3)); code = RANGE_X1; end
            default: begin
               bw   = $urandom_range(61, 3);
               q    = (rand64() & ((64'd1 << bw) - 1)) | (64'd1 << (bw - 1));
               code = 2'($urandom_range(3));
            end
         endcase
         lim = q << code;
         mu  = (phase % 7 == 6) ? (rand64() >> 1) : barrett_for(q);
         add = 1'($urandom_range(1));

         y_sel = $urandom_range(15);
         if (y_sel == 0) y = 64'd0;
         else if (y_sel == 1) y = lim - 1;
         else if (y_sel == 2 && phase == 7) y = lim;
         else y = rand64() % lim;

         q_word     = q;
         range_word = {62'd0, code};
         if ($urandom_range(3) == 0) begin
            q_word[63:61]     = 3'($urandom_range(7));
            range_word[63:2]  = 62'({$urandom, $urandom});
         end
         apply_settings(q_word, mu, y, range_word, {$urandom, $urandom_range(1)} | 64'(add),
                        1'b0);

         n_items = $urandom_range(80, 40);
         for (i = 0; i < n_items; i++) begin
            // Long result hold-off while items keep coming, so the pipeline backs up.
            if (phase == 2 && i == 10) hold_req = 1'b1;
            // One mid-phase pause until the pipeline is empty.
            if (phase == 3 && i == 30) drain_pipeline();
            send_item(pick_operand(), add ? pick_operand() : rand64(),
                      ($urandom_range(5) == 0));
         end
      end

      drain_pipeline();
      repeat (3 * NSTAGE) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[modular_multiply_add_barrett_core] OK");
      end else begin
         $display("[modular_multiply_add_barrett_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
